FILE: rtl/date_time_field_scanner_top_assert.svh
// Assertion macros used by the checker of the field scanner.
`ifndef DATE_TIME_FIELD_SCANNER_TOP_ASSERT_SVH
`define DATE_TIME_FIELD_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DTFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtfs check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DTFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtfs check failed");

`endif

FILE: rtl/dtfs_pkg.sv
package dtfs_pkg;

    // Field kinds as carried on the input operation field.
    localparam logic [2:0] KIND_SECOND = 3'd0;
    localparam logic [2:0] KIND_MINUTE = 3'd1;
    localparam logic [2:0] KIND_HOUR   = 3'd2;
    localparam logic [2:0] KIND_DAY    = 3'd3;
    localparam logic [2:0] KIND_MONTH  = 3'd4;
    localparam logic [2:0] KIND_YEAR   = 3'd5;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_FINE      = 3'd0,
        ST_NOT_DIGIT = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NO_READ   = 3'd4
    } status_t;

    // Character codes.
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;

    // Year limits.
    localparam logic [13:0] YEAR_MIN = 14'd1912;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // Widths of the stream words.
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Terminator accepted after the digits of each kind.
    function automatic logic is_term(input logic [2:0] kind, input logic [7:0] c);
        logic res;
        case (kind) inside
            KIND_SECOND, KIND_DAY: res = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
            KIND_MINUTE, KIND_HOUR: res = (c == CH_COLON);
            default: res = (c == CH_DOT) || (c == CH_HYPHEN);
        endcase
        return res;
    endfunction

    // Tens/units pattern that keeps a two-digit field inside its range.
    function automatic logic pair_ok(input logic [2:0] kind, input logic [3:0] a,
                                     input logic [3:0] b);
        logic res;
        case (kind) inside
            KIND_SECOND, KIND_MINUTE: res = (a <= 4'd5);
            KIND_HOUR: res = (a <= 4'd1) || ((a == 4'd2) && (b <= 4'd3));
            KIND_DAY: res = (a <= 4'd2) || ((a == 4'd3) && (b <= 4'd1));
            default: res = (a == 4'd0) || ((a == 4'd1) && (b <= 4'd2));
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/date_time_field_scanner_top.sv
// Date and time field scanner.
// The input channel (s_*) carries one character per transaction in s_tdata,
// with the field kind and an end-of-stream flag in s_tuser. The kind is taken
// only on the first character of a token. Second, minute, hour, day and month
// take one or two digits and a terminator; a year takes four digits and one
// terminator. When a token is decided, one transaction leaves on the output
// channel (m_*): status in m_tuser, value and rewind offset in m_tdata.
// One character per cycle when not stalled: all decoding is a single pass of
// logic from the scan state and the incoming character into the output
// register. A result appears on m_tvalid in the cycle after the character
// that decides it. If the receiver stalls while a result is held, s_tready
// drops until the result is taken; a character that decides nothing is still
// accepted when the output register is empty or being drained.
// Reset clears the scan state to idle between tokens and empties the output
// register; no result is pending after reset.
module date_time_field_scanner_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dtfs_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] char_in
    input  logic [dtfs_pkg::S_TUSER_W-1:0] s_tuser,  // [2:0] operation, [3] stream_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dtfs_pkg::M_TDATA_W-1:0] m_tdata,  // [13:0] value, [16:14] rewind_offset
    output logic [dtfs_pkg::M_TUSER_W-1:0] m_tuser   // [2:0] status
);

    logic [2:0]  pos_reg, pos_next;
    logic [2:0]  kind_reg, kind_next;
    logic [3:0]  d1_reg, d1_next;
    logic [3:0]  d2_reg, d2_next;
    logic [13:0] acc_reg, acc_next;
    logic [2:0]  early_reg, early_next;

    logic            out_valid_reg;
    dtfs_pkg::status_t out_status_reg;
    logic [13:0]     out_value_reg;
    logic [2:0]      out_off_reg;

    logic [2:0]  op;
    logic [7:0]  ch;
    logic        end_flag;
    logic        accept;
    logic        fire;
    dtfs_pkg::status_t res_status;
    logic [13:0] res_value;
    logic [2:0]  res_off;

    logic [2:0]  kind_cur;
    logic [2:0]  early_cur;
    logic [13:0] acc_cur;
    logic [3:0]  dig;
    logic [17:0] acc_times10;
    logic [6:0]  pair_val;
    logic [6:0]  pair_val_held;
    logic        ch_digit;
    logic        ch_term;
    logic        ch_year_term;
    logic        day_month;

    assign op       = s_tuser[2:0];
    assign end_flag = s_tuser[3];
    assign ch       = s_tdata[7:0];

    // The input side stalls only while a finished result waits.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Values seen by the scan step; a new token starts from cleared state.
    assign kind_cur  = (pos_reg == 3'd0) ? op : kind_reg;
    assign early_cur = (pos_reg == 3'd0) ? 3'd0 : early_reg;
    assign acc_cur   = (pos_reg == 3'd0) ? 14'd0 : acc_reg;
    assign dig       = 4'(ch - dtfs_pkg::CH_ZERO);
    assign ch_digit  = dtfs_pkg::is_digit(ch);
    assign ch_term   = dtfs_pkg::is_term(kind_cur, ch);
    assign ch_year_term = (ch == dtfs_pkg::CH_DOT) || (ch == dtfs_pkg::CH_HYPHEN);
    assign day_month = (kind_cur == dtfs_pkg::KIND_DAY) || (kind_cur == dtfs_pkg::KIND_MONTH);
    assign acc_times10 = {acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0};
    assign pair_val      = 7'({d1_reg, 3'b000} + {2'b00, d1_reg, 1'b0}) + 7'(dig);
    assign pair_val_held = 7'({d1_reg, 3'b000} + {2'b00, d1_reg, 1'b0}) + 7'(d2_reg);

    // Scan step: next state and the result a character decides.
    always_comb
    begin
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        acc_next   = acc_reg;
        early_next = early_reg;
        fire       = 1'b0;
        res_status = dtfs_pkg::ST_FINE;
        res_value  = 14'd0;
        res_off    = 3'd0;

        if ((pos_reg == 3'd0) && end_flag)
        begin
            fire       = 1'b1;
            res_status = dtfs_pkg::ST_NO_READ;
        end
        else if ((pos_reg == 3'd0) && (op > dtfs_pkg::KIND_YEAR))
        begin
            kind_next  = op;
            fire       = 1'b1;
            res_status = dtfs_pkg::ST_MALFORMED;
            res_off    = 3'd1;
        end
        else
        begin
            if (pos_reg == 3'd0)
            begin
                kind_next  = op;
                d1_next    = 4'd0;
                d2_next    = 4'd0;
                acc_next   = 14'd0;
                early_next = 3'd0;
            end

            if (kind_cur == dtfs_pkg::KIND_YEAR)
            begin
                if (end_flag)
                begin
                    fire       = 1'b1;
                    res_status = (early_cur != 3'd0) ? dtfs_pkg::status_t'(early_cur)
                                                     : dtfs_pkg::ST_NO_READ;
                    res_off    = pos_reg;
                end
                else if (pos_reg < 3'd4)
                begin
                    // Note the first failure, else accumulate the digit.
                    if (early_cur == 3'd0)
                    begin
                        if (!ch_digit)
                            early_next = (pos_reg == 3'd0) ? 3'(dtfs_pkg::ST_NOT_DIGIT)
                                                           : 3'(dtfs_pkg::ST_MALFORMED);
                        else if ((pos_reg == 3'd0) && (ch == dtfs_pkg::CH_ZERO))
                            early_next = 3'(dtfs_pkg::ST_RANGE);
                        else
                            acc_next = 14'(acc_times10 + 18'(dig));
                    end
                    pos_next = pos_reg + 3'd1;
                end
                else
                begin
                    fire    = 1'b1;
                    res_off = 3'd5;
                    if (early_cur != 3'd0)
                        res_status = dtfs_pkg::status_t'(early_cur);
                    else if (!ch_year_term)
                        res_status = dtfs_pkg::ST_MALFORMED;
                    else if ((acc_cur >= dtfs_pkg::YEAR_MIN) && (acc_cur <= dtfs_pkg::YEAR_MAX))
                    begin
                        res_status = dtfs_pkg::ST_FINE;
                        res_value  = acc_cur;
                        res_off    = 3'd1;
                    end
                    else
                    begin
                        res_status = dtfs_pkg::ST_RANGE;
                        res_value  = acc_cur;
                    end
                end
            end
            else if (pos_reg == 3'd0)
            begin
                // First character of a one- or two-digit field.
                if (!ch_digit)
                begin
                    fire       = 1'b1;
                    res_status = dtfs_pkg::ST_NOT_DIGIT;
                    res_off    = 3'd1;
                end
                else
                begin
                    d1_next  = dig;
                    pos_next = 3'd1;
                end
            end
            else if (end_flag)
            begin
                fire       = 1'b1;
                res_status = dtfs_pkg::ST_NO_READ;
                res_off    = pos_reg;
            end
            else if (pos_reg == 3'd1)
            begin
                // Second character: terminator or second digit.
                if (ch_term)
                begin
                    fire = 1'b1;
                    if (day_month && (d1_reg == 4'd0))
                    begin
                        res_status = dtfs_pkg::ST_RANGE;
                        res_off    = 3'd2;
                    end
                    else
                    begin
                        res_value = 14'(d1_reg);
                        res_off   = 3'd1;
                    end
                end
                else if (!ch_digit)
                begin
                    fire       = 1'b1;
                    res_status = dtfs_pkg::ST_MALFORMED;
                    res_off    = 3'd2;
                end
                else
                begin
                    d2_next = dig;
                    if (!dtfs_pkg::pair_ok(kind_cur, d1_reg, dig))
                    begin
                        fire       = 1'b1;
                        res_status = dtfs_pkg::ST_RANGE;
                        res_value  = 14'(pair_val);
                        res_off    = 3'd2;
                    end
                    else
                        pos_next = 3'd2;
                end
            end
            else
            begin
                // Third character must terminate a two-digit field.
                fire    = 1'b1;
                res_off = 3'd3;
                if (ch_term)
                begin
                    if (day_month && (d1_reg == 4'd0) && (d2_reg == 4'd0))
                        res_status = dtfs_pkg::ST_RANGE;
                    else
                    begin
                        res_value = 14'(pair_val_held);
                        res_off   = 3'd1;
                    end
                end
                else
                    res_status = dtfs_pkg::ST_MALFORMED;
            end
        end

        if (fire)
            pos_next = 3'd0;
    end

    // Scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 3'd0;
            kind_reg  <= 3'd0;
            d1_reg    <= 4'd0;
            d2_reg    <= 4'd0;
            acc_reg   <= 14'd0;
            early_reg <= 3'd0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            acc_reg   <= acc_next;
            early_reg <= early_next;
        end
    end

    // Output register: loads a decided result, empties when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && fire)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
            out_off_reg    <= res_off;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_off_reg, out_value_reg};

endmodule

FILE: rtl/dtfs_checker.sv
`include "date_time_field_scanner_top_assert.svh"

// Port-level checks of the field scanner.
module dtfs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dtfs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [dtfs_pkg::M_TUSER_W-1:0] m_tuser
);

    logic        stalled;
    logic        value_defined;
    logic [13:0] out_value;
    logic [2:0]  out_off;

    // Views of the output transaction used by the checks.
    assign stalled       = m_tvalid && !m_tready;
    assign value_defined = (m_tuser == dtfs_pkg::ST_FINE) || (m_tuser == dtfs_pkg::ST_RANGE);
    assign out_value     = m_tdata[13:0];
    assign out_off       = m_tdata[16:14];

    // A stalled result holds its transaction.
    `DTFS_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A stalled output register blocks the input side.
    `DTFS_ASSERT_NOW(a_stall_blocks_input, stalled, !s_tready)

    // A recognized token always rewinds by one character.
    `DTFS_ASSERT_NOW(a_fine_offset, m_tvalid && (m_tuser == dtfs_pkg::ST_FINE), out_off == 3'd1)

    // Only fine and out-of-range results carry a value.
    `DTFS_ASSERT_NOW(a_value_zero, m_tvalid && !value_defined, out_value == 14'd0)

endmodule

bind date_time_field_scanner_top dtfs_checker u_dtfs_checker (.*);

FILE: tb/sv/testbench.sv
module testbench;
    import dtfs_pkg::*;

    // Kinds with no field assigned; the scanner rejects them at token start.
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int REPORT_CAP    = 40;

    // One pending character for the input channel.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       eos;
    } scan_char_t;

    // One predicted scan result.
    typedef struct packed {
        status_t     status;
        logic [13:0] value;
        logic [2:0]  offset;
    } scan_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // [7:0] char_in
    logic [S_TUSER_W-1:0] s_tuser = '0;   // [2:0] operation, [3] stream_end
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // [13:0] value, [16:14] rewind_offset
    logic [M_TUSER_W-1:0] m_tuser;        // [2:0] status

    date_time_field_scanner_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    scan_char_t   char_queue[$];
    scan_result_t result_queue[$];

    int error_count   = 0;
    int stim_count    = 0;
    int chars_seen    = 0;
    int results_seen  = 0;
    int idle_cycles   = 0;
    int status_seen[5];

    // Shadow of the scanner state.
    logic [2:0]  scan_pos   = 3'd0;
    logic [2:0]  scan_kind  = 3'd0;
    logic [3:0]  tens_digit = 4'd0;
    logic [3:0]  units_digit = 4'd0;
    logic [13:0] year_acc   = 14'd0;
    status_t     year_fail  = ST_FINE;

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Terminator that closes a field of the given kind.
    function automatic logic ends_field(input logic [2:0] kind, input logic [7:0] c);
        if (kind == KIND_SECOND || kind == KIND_DAY)
            return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
        if (kind == KIND_MINUTE || kind == KIND_HOUR)
            return c == CH_COLON;
        return (c == CH_DOT) || (c == CH_HYPHEN);
    endfunction

    // Whether two digits can still form a value inside the kind's range.
    function automatic logic tens_fits(input logic [2:0] kind, input logic [3:0] a,
                                       input logic [3:0] b);
        case (kind)
            KIND_SECOND, KIND_MINUTE: return a <= 4'd5;
            KIND_HOUR: return (a <= 4'd1) || (a == 4'd2 && b <= 4'd3);
            KIND_DAY: return (a <= 4'd2) || (a == 4'd3 && b <= 4'd1);
            default: return (a == 4'd0) || (a == 4'd1 && b <= 4'd2);
        endcase
    endfunction

    task automatic post_result(input status_t st, input logic [13:0] val,
                               input logic [2:0] off);
        scan_result_t r;
        r.status = st;
        r.value  = val;
        r.offset = off;
        result_queue.push_back(r);
        scan_pos = 3'd0;
    endtask

    // Advance the shadow scanner by one accepted character.
    task automatic scan_step(input logic [2:0] op, input logic [7:0] c, input logic eos);
        logic [3:0]  dig;
        logic [13:0] pair_val;
        dig = 4'(c - CH_ZERO);

        // Token start: latch the kind and clear the digit state.
        if (scan_pos == 3'd0)
        begin
            if (eos)
            begin
                post_result(ST_NO_READ, 14'd0, 3'd0);
                return;
            end
            scan_kind   = op;
            tens_digit  = 4'd0;
            units_digit = 4'd0;
            year_acc    = 14'd0;
            year_fail   = ST_FINE;
            if (scan_kind > KIND_YEAR)
            begin
                post_result(ST_MALFORMED, 14'd0, 3'd1);
                return;
            end
        end

        // A year runs for five characters unless the stream ends first, noting the first failure.
        if (scan_kind == KIND_YEAR)
        begin
            if (eos)
            begin
                if (year_fail != ST_FINE)
                    post_result(year_fail, 14'd0, scan_pos);
                else
                    post_result(ST_NO_READ, 14'd0, scan_pos);
            end
            else if (scan_pos < 3'd4)
            begin
                if (year_fail == ST_FINE)
                begin
                    if (!is_decimal(c))
                    begin
                        if (scan_pos == 3'd0)
                            year_fail = ST_NOT_DIGIT;
                        else
                            year_fail = ST_MALFORMED;
                    end
                    else if (scan_pos == 3'd0 && c == CH_ZERO)
                        year_fail = ST_RANGE;
                    else
                        year_acc = year_acc * 14'd10 + 14'(dig);
                end
                scan_pos = scan_pos + 3'd1;
            end
            else if (year_fail != ST_FINE)
                post_result(year_fail, 14'd0, 3'd5);
            else if (!(c == CH_DOT || c == CH_HYPHEN))
                post_result(ST_MALFORMED, 14'd0, 3'd5);
            else if (year_acc >= YEAR_MIN && year_acc <= YEAR_MAX)
                post_result(ST_FINE, year_acc, 3'd1);
            else
                post_result(ST_RANGE, year_acc, 3'd5);
            return;
        end

        // Two-digit kinds.
        if (scan_pos == 3'd0)
        begin
            if (!is_decimal(c))
                post_result(ST_NOT_DIGIT, 14'd0, 3'd1);
            else
            begin
                tens_digit = dig;
                scan_pos   = 3'd1;
            end
            return;
        end
        if (eos)
        begin
            post_result(ST_NO_READ, 14'd0, scan_pos);
            return;
        end
        if (scan_pos == 3'd1)
        begin
            if (ends_field(scan_kind, c))
            begin
                if ((scan_kind == KIND_DAY || scan_kind == KIND_MONTH) && tens_digit == 4'd0)
                    post_result(ST_RANGE, 14'd0, 3'd2);
                else
                    post_result(ST_FINE, 14'(tens_digit), 3'd1);
            end
            else if (!is_decimal(c))
                post_result(ST_MALFORMED, 14'd0, 3'd2);
            else
            begin
                units_digit = dig;
                pair_val = 14'(tens_digit) * 14'd10 + 14'(units_digit);
                if (!tens_fits(scan_kind, tens_digit, units_digit))
                    post_result(ST_RANGE, pair_val, 3'd2);
                else
                    scan_pos = 3'd2;
            end
            return;
        end
        pair_val = 14'(tens_digit) * 14'd10 + 14'(units_digit);
        if (ends_field(scan_kind, c))
        begin
            if ((scan_kind == KIND_DAY || scan_kind == KIND_MONTH) &&
                tens_digit == 4'd0 && units_digit == 4'd0)
                post_result(ST_RANGE, 14'd0, 3'd3);
            else
                post_result(ST_FINE, pair_val, 3'd1);
        end
        else
            post_result(ST_MALFORMED, 14'd0, 3'd3);
    endtask

    task automatic push_char(input logic [2:0] kind, input logic [7:0] ch, input logic eos);
        scan_char_t item;
        item.kind = kind;
        item.ch   = ch;
        item.eos  = eos;
        char_queue.push_back(item);
        stim_count++;
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        error_count++;
        if (error_count <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        scan_char_t item;
        logic       next_valid;
        if (rst_n)
        begin
            if (!s_tvalid || s_tready)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (char_queue.size() > 0)
                begin
                    item = char_queue.pop_front();
                    s_tdata <= item.ch;
                    s_tuser <= {item.eos, item.kind};
                    next_valid = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                s_tvalid <= next_valid;
            end
        end
    end

    // Receiver: stall pattern switches between several modes.
    int         rx_mode  = 0;
    int         rx_left  = 0;
    logic [7:0] rx_phase = 8'd0;

    always @(posedge clk)
    begin
        logic ready;
        if (rst_n)
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(50, 300);
            end
            else
                rx_left--;
            rx_phase = rx_phase + 8'd1;
            case (rx_mode)
                0: ready = 1'b1;
                1: ready = $urandom_range(0, 3) != 0;
                2: ready = $urandom_range(0, 9) < 3;
                default: ready = rx_phase[1:0] != 2'd3;
            endcase
            m_tready <= ready;
        end
    end

    // Monitor: predict on each input transaction, check each output transaction.
    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;

            if (s_tvalid && s_tready)
            begin
                scan_step(s_tuser[2:0], s_tdata, s_tuser[3]);
                chars_seen++;
            end

            if (m_tvalid && m_tready)
            begin
                if (result_queue.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_CAP)
                        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                                 $time, m_tuser, m_tdata[13:0], m_tdata[16:14]);
                end
                else
                begin
                    want = result_queue.pop_front();
                    results_seen++;
                    status_seen[want.status]++;
                    if (m_tuser[2:0] != want.status)
                        report_mismatch("status", want.status, m_tuser[2:0]);
                    if (m_tdata[13:0] != want.value)
                        report_mismatch("value", want.value, m_tdata[13:0]);
                    if (m_tdata[16:14] != want.offset)
                        report_mismatch("rewind_offset", want.offset, m_tdata[16:14]);
                    if (m_tdata[M_TDATA_W-1:17] != '0)
                        report_mismatch("tdata padding", 0, m_tdata[M_TDATA_W-1:17]);
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [2:0] kind;
        logic [7:0] tok [0:5];
        int         n;
        int         cut;
        int         roll;
        int         v;
        int         lo;
        int         hi;
        int         div;
        logic       timed_out;

        for (int i = 0; i < 5; i++)
            status_seen[i] = 0;

        // Directed tokens: range edges, each kind, and the corner cases.
        push_char(KIND_SECOND, "5", 1'b0);
        push_char(KIND_MINUTE, "9", 1'b0);
        push_char(KIND_HOUR, CH_TAB, 1'b0);
        push_char(KIND_MINUTE, "0", 1'b0);
        push_char(KIND_SECOND, CH_COLON, 1'b0);
        push_char(KIND_HOUR, "2", 1'b0);
        push_char(KIND_HOUR, "4", 1'b0);
        push_char(KIND_DAY, "0", 1'b0);
        push_char(KIND_DAY, "0", 1'b0);
        push_char(KIND_DAY, CH_LF, 1'b0);
        push_char(KIND_MONTH, "0", 1'b0);
        push_char(KIND_MONTH, CH_HYPHEN, 1'b0);
        push_char(KIND_YEAR, "9", 1'b0);
        push_char(KIND_YEAR, "9", 1'b0);
        push_char(KIND_YEAR, "9", 1'b0);
        push_char(KIND_YEAR, "9", 1'b0);
        push_char(KIND_YEAR, CH_DOT, 1'b0);
        // A year with a leading zero cut short by the end of the stream.
        push_char(KIND_YEAR, "0", 1'b0);
        push_char(KIND_MONTH, 8'hA5, 1'b1);
        // Unassigned kind, end of stream while idle, and a control byte.
        push_char(KIND_SPARE_HI, 8'hFF, 1'b0);
        push_char(KIND_SECOND, 8'h00, 1'b1);
        push_char(KIND_SECOND, 8'h00, 1'b0);
        push_char(KIND_SPARE_LO, "1", 1'b0);

        // Random part: mostly plausible tokens, with noise and broken ones mixed in.
        while (stim_count < RANDOM_ITEMS + 23)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                push_char(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          $urandom_range(0, 7) == 0);
            else if (roll < 11)
                push_char(($urandom_range(0, 1) != 0) ? KIND_SPARE_HI : KIND_SPARE_LO,
                          8'($urandom_range(0, 255)), 1'b0);
            else
            begin
                kind = 3'($urandom_range(0, 5));
                if (kind == KIND_YEAR)
                begin
                    if ($urandom_range(0, 3) == 0)
                        v = $urandom_range(0, 9999);
                    else
                        v = $urandom_range(1912, 9999);
                    div = 1000;
                    for (int i = 0; i < 4; i++)
                    begin
                        tok[i] = CH_ZERO + 8'((v / div) % 10);
                        div = div / 10;
                    end
                    n = 4;
                end
                else
                begin
                    case (kind)
                        KIND_HOUR:  begin lo = 0; hi = 23; end
                        KIND_DAY:   begin lo = 1; hi = 31; end
                        KIND_MONTH: begin lo = 1; hi = 12; end
                        default:    begin lo = 0; hi = 59; end
                    endcase
                    if ($urandom_range(0, 4) == 0)
                        v = $urandom_range(0, 99);
                    else
                        v = $urandom_range(lo, hi);
                    if (v >= 10 || $urandom_range(0, 3) == 0)
                    begin
                        tok[0] = CH_ZERO + 8'(v / 10);
                        tok[1] = CH_ZERO + 8'(v % 10);
                        n = 2;
                    end
                    else
                    begin
                        tok[0] = CH_ZERO + 8'(v);
                        n = 1;
                    end
                end

                // Occasionally corrupt a digit.
                for (int i = 0; i < n; i++)
                    if ($urandom_range(0, 24) == 0)
                        tok[i] = 8'($urandom_range(0, 255));

                // Terminator: mostly the right one, sometimes wrong or extra digits.
                roll = $urandom_range(0, 9);
                if (roll <= 6)
                begin
                    if (kind == KIND_SECOND || kind == KIND_DAY)
                    begin
                        case ($urandom_range(0, 2))
                            0: tok[n] = CH_SPACE;
                            1: tok[n] = CH_TAB;
                            default: tok[n] = CH_LF;
                        endcase
                    end
                    else if (kind == KIND_MINUTE || kind == KIND_HOUR)
                        tok[n] = CH_COLON;
                    else
                        tok[n] = ($urandom_range(0, 1) != 0) ? CH_DOT : CH_HYPHEN;
                end
                else if (roll == 7)
                begin
                    case ($urandom_range(0, 5))
                        0: tok[n] = CH_SPACE;
                        1: tok[n] = CH_TAB;
                        2: tok[n] = CH_LF;
                        3: tok[n] = CH_COLON;
                        4: tok[n] = CH_DOT;
                        default: tok[n] = CH_HYPHEN;
                    endcase
                end
                else if (roll == 8)
                    tok[n] = CH_ZERO + 8'($urandom_range(0, 9));
                else
                    tok[n] = 8'($urandom_range(0, 255));
                n++;

                // Sometimes the stream ends partway through the token.
                if ($urandom_range(0, 14) == 0)
                    cut = $urandom_range(0, n - 1);
                else
                    cut = n;

                for (int i = 0; i < cut; i++)
                begin
                    if (i == 0)
                        push_char(kind, tok[i], 1'b0);
                    else
                        push_char(3'($urandom_range(0, 7)), tok[i], 1'b0);
                end
                if (cut < n)
                    push_char(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b1);
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all characters to go in and all results to come out.
        while ((char_queue.size() != 0 || s_tvalid || result_queue.size() != 0) &&
               idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        timed_out = idle_cycles >= IDLE_LIMIT;
        if (timed_out)
            $display("%0t: watchdog expired after %0d idle cycles", $time, idle_cycles);
        else
            repeat (DRAIN_CYCLES) @(posedge clk);

        if (result_queue.size() != 0)
        begin
            error_count += result_queue.size();
            $display("%0t: %0d expected results never arrived", $time, result_queue.size());
        end

        $display("Scanned %0d characters and checked %0d results.", chars_seen, results_seen);
        $display("Statuses seen: fine %0d, not digit %0d, malformed %0d, range %0d, no read %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);

        if (!timed_out && error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
